// ===== rtl/tdba_pkg.sv =====
package tdba_pkg;

  localparam int NUM_LEVELS  = 3;
  localparam int SLOT_W      = 10;
  localparam int UNITS_W     = 11;
  localparam int ADDR_W      = 32;
  localparam int BYTES_W     = 18;
  localparam int REQ_W       = 8;
  localparam int STATUS_W    = 2;
  localparam int LEVEL_W     = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 2;

  // request opcodes
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_BUF    = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_TOO_LARGE = 2'd2;

  // size classes
  localparam logic [LEVEL_W-1:0] LEVEL_0 = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_1 = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_2 = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_REGION_BASE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL1_BASE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL2_BASE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL0_UNITS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL1_UNITS = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL2_UNITS = 3'd5;

  typedef logic [LEVEL_W-1:0] level_t;

  // classified request as it leaves the front end
  typedef struct packed {
    logic              is_free;
    logic              too_large;
    level_t            level;
    logic [SLOT_W-1:0] slot;
  } req_t;

  typedef struct packed {
    logic [NUM_LEVELS-1:0][ADDR_W-1:0]  base;
    logic [NUM_LEVELS-1:0][UNITS_W-1:0] units;
  } cfg_t;

endpackage

// ===== rtl/tdba_front.sv =====
module tdba_front #(
  parameter int LEVEL0_BLOCKS = 1,
  parameter int LEVEL1_BLOCKS = 8,
  parameter int LEVEL2_BLOCKS = 32,
  parameter int BLOCK_BYTES   = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_op,
  input  logic [tdba_pkg::REQ_W-1:0]       in_request_blocks,
  input  logic [tdba_pkg::BYTES_W-1:0]     in_buffer_bytes,
  input  logic [tdba_pkg::SLOT_W-1:0]      in_buffer_slot,
  output logic                             push_valid,
  input  logic                             push_full,
  output tdba_pkg::req_t                   push_item
);

  localparam logic [31:0] UNIT_BYTES0 = 32'(LEVEL0_BLOCKS * BLOCK_BYTES);
  localparam logic [31:0] UNIT_BYTES1 = 32'(LEVEL1_BLOCKS * BLOCK_BYTES);
  localparam logic [31:0] UNIT_BYTES2 = 32'(LEVEL2_BLOCKS * BLOCK_BYTES);
  localparam logic [31:0] BLOCKS0     = 32'(LEVEL0_BLOCKS);
  localparam logic [31:0] BLOCKS1     = 32'(LEVEL1_BLOCKS);
  localparam logic [31:0] BLOCKS2     = 32'(LEVEL2_BLOCKS);

  logic           valid_r, valid_nxt;
  tdba_pkg::req_t item_r, item_nxt;
  logic [31:0]    size_w;
  logic [31:0]    lim0, lim1, lim2;
  logic           load;

  assign in_stall   = valid_r & push_full;
  assign load       = in_valid & ~in_stall;
  assign push_valid = valid_r;
  assign push_item  = item_r;

  // free sizes by bytes, allocations by blocks
  always_comb begin
    item_nxt         = '0;
    item_nxt.is_free = (in_op == tdba_pkg::OP_FREE);
    item_nxt.slot    = in_buffer_slot;
    if (item_nxt.is_free) begin
      size_w = 32'(in_buffer_bytes);
      lim0   = UNIT_BYTES0;
      lim1   = UNIT_BYTES1;
      lim2   = UNIT_BYTES2;
    end else begin
      size_w = 32'(in_request_blocks);
      lim0   = BLOCKS0;
      lim1   = BLOCKS1;
      lim2   = BLOCKS2;
    end
    if (size_w <= lim0) begin
      item_nxt.level = tdba_pkg::LEVEL_0;
    end else if (size_w <= lim1) begin
      item_nxt.level = tdba_pkg::LEVEL_1;
    end else if (size_w <= lim2) begin
      item_nxt.level = tdba_pkg::LEVEL_2;
    end else begin
      item_nxt.too_large = 1'b1;
    end
  end

  assign valid_nxt = load | (valid_r & push_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (load) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== rtl/tdba_queue.sv =====
module tdba_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_full,
  input  tdba_pkg::req_t push_item,
  output logic           pop_valid,
  input  logic           pop,
  output tdba_pkg::req_t pop_item
);

  localparam int QD  = tdba_pkg::QUEUE_DEPTH;
  localparam int QPW = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCW = $clog2(QD + 1);

  tdba_pkg::req_t       entry_r [QD];
  logic [QPW-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]       count_r, count_nxt;
  logic                 do_push, do_pop;

  assign push_full = (count_r == QCW'(QD));
  assign pop_valid = (count_r != '0);
  assign pop_item  = entry_r[rd_ptr_r];
  assign do_push   = push_valid & ~push_full;
  assign do_pop    = pop & pop_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPW'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPW'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

// ===== rtl/tdba_back.sv =====
module tdba_back #(
  parameter int LEVEL0_BLOCKS = 1,
  parameter int LEVEL1_BLOCKS = 8,
  parameter int LEVEL2_BLOCKS = 32,
  parameter int BLOCK_BYTES   = 4096,
  parameter int MAX_SLOTS     = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tdba_pkg::cfg_t                cfg,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  tdba_pkg::req_t                q_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [tdba_pkg::STATUS_W-1:0] out_status,
  output logic [tdba_pkg::LEVEL_W-1:0]  out_granted_level,
  output logic [tdba_pkg::SLOT_W-1:0]   out_granted_slot,
  output logic [tdba_pkg::ADDR_W-1:0]   out_granted_address,
  output logic [tdba_pkg::BYTES_W-1:0]  out_granted_bytes
);

  localparam int NL        = tdba_pkg::NUM_LEVELS;
  localparam int SW        = tdba_pkg::SLOT_W;
  localparam int AW        = tdba_pkg::ADDR_W;
  localparam int BW        = tdba_pkg::BYTES_W;
  localparam int PW        = $clog2(MAX_SLOTS);
  localparam int CW        = $clog2(MAX_SLOTS + 1);
  localparam int MAW       = tdba_pkg::LEVEL_W + PW;
  localparam int MEM_DEPTH = NL * (2 ** PW);

  localparam logic [AW-1:0] UNIT_BYTES0 = AW'(LEVEL0_BLOCKS * BLOCK_BYTES);
  localparam logic [AW-1:0] UNIT_BYTES1 = AW'(LEVEL1_BLOCKS * BLOCK_BYTES);
  localparam logic [AW-1:0] UNIT_BYTES2 = AW'(LEVEL2_BLOCKS * BLOCK_BYTES);

  typedef enum logic {S_IDLE, S_FIN} state_t;

  state_t                   state_r, state_nxt;
  logic [NL-1:0][CW-1:0]    fresh_r, fresh_nxt;
  logic [NL-1:0][PW-1:0]    head_r, head_nxt;
  logic [NL-1:0][PW-1:0]    tail_r, tail_nxt;
  logic [NL-1:0][CW-1:0]    count_r, count_nxt;

  // held between the decide and finish steps
  tdba_pkg::level_t         lvl_r, lvl_nxt;
  logic [SW-1:0]            slot_r, slot_nxt;
  logic                     from_mem_r, from_mem_nxt;
  logic [1:0]               status_r, status_nxt;

  logic                     out_valid_r, out_valid_nxt;
  logic [1:0]               out_status_r, out_status_nxt;
  tdba_pkg::level_t         out_level_r, out_level_nxt;
  logic [SW-1:0]            out_slot_r, out_slot_nxt;
  logic [AW-1:0]            out_addr_r, out_addr_nxt;
  logic [BW-1:0]            out_bytes_r, out_bytes_nxt;

  // free-list memory, one ring per level
  logic [SW-1:0]            slot_mem [MEM_DEPTH];
  logic [SW-1:0]            rd_data_r;
  logic                     mem_we, mem_re;
  logic [MAW-1:0]           mem_waddr, mem_raddr;

  logic [NL-1:0][CW-1:0]    units_cl;
  logic [NL-1:0]            fresh_left, avail;
  logic                     sel_ok;
  tdba_pkg::level_t         sel_lvl;
  logic [SW-1:0]            fin_slot;
  logic [AW-1:0]            unit_sel, base_sel, prod;
  logic                     out_free;

  // per-level availability
  always_comb begin
    for (int l = 0; l < NL; l++) begin
      units_cl[l]   = (cfg.units[l] > tdba_pkg::UNITS_W'(MAX_SLOTS)) ?
                      CW'(MAX_SLOTS) : CW'(cfg.units[l]);
      fresh_left[l] = (units_cl[l] > fresh_r[l]);
      avail[l]      = fresh_left[l] | (count_r[l] != '0);
    end
  end

  // smallest level at or above the requested one that has a slot
  always_comb begin
    sel_ok  = 1'b1;
    sel_lvl = tdba_pkg::LEVEL_2;
    if (q_item.level == tdba_pkg::LEVEL_0 && avail[0]) begin
      sel_lvl = tdba_pkg::LEVEL_0;
    end else if (q_item.level != tdba_pkg::LEVEL_2 && avail[1]) begin
      sel_lvl = tdba_pkg::LEVEL_1;
    end else if (avail[2]) begin
      sel_lvl = tdba_pkg::LEVEL_2;
    end else begin
      sel_ok = 1'b0;
    end
  end

  // address arithmetic for the finish step
  always_comb begin
    case (lvl_r)
      tdba_pkg::LEVEL_0: begin
        unit_sel = UNIT_BYTES0;
        base_sel = cfg.base[0];
      end
      tdba_pkg::LEVEL_1: begin
        unit_sel = UNIT_BYTES1;
        base_sel = cfg.base[1];
      end
      default: begin
        unit_sel = UNIT_BYTES2;
        base_sel = cfg.base[2];
      end
    endcase
    fin_slot = from_mem_r ? rd_data_r : slot_r;
    prod     = AW'(fin_slot) * unit_sel;
  end

  assign out_free = ~out_valid_r | ~out_stall;

  always_comb begin
    state_nxt      = state_r;
    fresh_nxt      = fresh_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    lvl_nxt        = lvl_r;
    slot_nxt       = slot_r;
    from_mem_nxt   = from_mem_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_status_nxt = out_status_r;
    out_level_nxt  = out_level_r;
    out_slot_nxt   = out_slot_r;
    out_addr_nxt   = out_addr_r;
    out_bytes_nxt  = out_bytes_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_waddr      = '0;
    mem_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (q_valid) begin
          q_pop        = 1'b1;
          state_nxt    = S_FIN;
          from_mem_nxt = 1'b0;
          slot_nxt     = q_item.slot;
          lvl_nxt      = q_item.level;
          status_nxt   = tdba_pkg::STATUS_DONE;
          if (q_item.too_large) begin
            status_nxt = tdba_pkg::STATUS_TOO_LARGE;
          end else if (q_item.is_free) begin
            // full ring drops the slot but still reports done
            if (count_r[q_item.level] != CW'(MAX_SLOTS)) begin
              mem_we                   = 1'b1;
              mem_waddr                = {q_item.level, tail_r[q_item.level]};
              tail_nxt[q_item.level]   = (tail_r[q_item.level] == PW'(MAX_SLOTS - 1)) ?
                                         '0 : tail_r[q_item.level] + 1'b1;
              count_nxt[q_item.level]  = count_r[q_item.level] + 1'b1;
            end
          end else if (!sel_ok) begin
            status_nxt = tdba_pkg::STATUS_NO_BUF;
          end else begin
            lvl_nxt = sel_lvl;
            if (fresh_left[sel_lvl]) begin
              slot_nxt           = SW'(fresh_r[sel_lvl]);
              fresh_nxt[sel_lvl] = fresh_r[sel_lvl] + 1'b1;
            end else begin
              mem_re             = 1'b1;
              mem_raddr          = {sel_lvl, head_r[sel_lvl]};
              from_mem_nxt       = 1'b1;
              head_nxt[sel_lvl]  = (head_r[sel_lvl] == PW'(MAX_SLOTS - 1)) ?
                                   '0 : head_r[sel_lvl] + 1'b1;
              count_nxt[sel_lvl] = count_r[sel_lvl] - 1'b1;
            end
          end
        end
      end
      S_FIN: begin
        if (out_free) begin
          state_nxt      = S_IDLE;
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          if (status_r == tdba_pkg::STATUS_DONE) begin
            out_level_nxt = lvl_r;
            out_slot_nxt  = fin_slot;
            out_addr_nxt  = base_sel + prod;
            out_bytes_nxt = unit_sel[BW-1:0];
          end else begin
            out_level_nxt = '0;
            out_slot_nxt  = '0;
            out_addr_nxt  = '0;
            out_bytes_nxt = '0;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fresh_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fresh_r      <= fresh_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      lvl_r        <= lvl_nxt;
      slot_r       <= slot_nxt;
      from_mem_r   <= from_mem_nxt;
      status_r     <= status_nxt;
      out_status_r <= out_status_nxt;
      out_level_r  <= out_level_nxt;
      out_slot_r   <= out_slot_nxt;
      out_addr_r   <= out_addr_nxt;
      out_bytes_r  <= out_bytes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= slot_nxt;
    end
    if (mem_re) begin
      rd_data_r <= slot_mem[mem_raddr];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_granted_level   = out_level_r;
  assign out_granted_slot    = out_slot_r;
  assign out_granted_address = out_addr_r;
  assign out_granted_bytes   = out_bytes_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r[0] <= CW'(MAX_SLOTS) && count_r[1] <= CW'(MAX_SLOTS) &&
    count_r[2] <= CW'(MAX_SLOTS))
    else $error("free-list count beyond ring size");

  a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fresh_r[0] <= CW'(MAX_SLOTS) && fresh_r[1] <= CW'(MAX_SLOTS) &&
    fresh_r[2] <= CW'(MAX_SLOTS))
    else $error("fresh pointer beyond slot range");

  a_fin_retires: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_FIN && out_free |=> state_r == S_IDLE && out_valid_r)
    else $error("finish step did not load the output register");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != tdba_pkg::STATUS_DONE |->
      out_addr_r == '0 && out_slot_r == '0 && out_bytes_r == '0 && out_level_r == '0)
    else $error("error result carries nonzero grant fields");

endmodule

// ===== rtl/tiered_dma_buffer_allocator.sv =====
// request path from accept to result valid: front register, queue write, decide step
//   and finish step into the output register; the finish step waits while the output stalls
// pacing: the back end takes a new request only once the last one's finish step is done,
//   since its decide/finish pair wraps the free-list memory's registered read
// reset: synchronous active-low rst_n clears config registers, pointers and counts;
//   the free-list memory is not cleared and is only read where already written
module tiered_dma_buffer_allocator #(
  parameter int LEVEL0_BLOCKS = 1,
  parameter int LEVEL1_BLOCKS = 8,
  parameter int LEVEL2_BLOCKS = 32,
  parameter int BLOCK_BYTES   = 4096,
  parameter int MAX_SLOTS     = 1024
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // request channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_op,
  input  logic [tdba_pkg::REQ_W-1:0]      in_request_blocks,
  input  logic [tdba_pkg::BYTES_W-1:0]    in_buffer_bytes,
  input  logic [tdba_pkg::SLOT_W-1:0]     in_buffer_slot,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [tdba_pkg::STATUS_W-1:0]   out_status,
  output logic [tdba_pkg::LEVEL_W-1:0]    out_granted_level,
  output logic [tdba_pkg::SLOT_W-1:0]     out_granted_slot,
  output logic [tdba_pkg::ADDR_W-1:0]     out_granted_address,
  output logic [tdba_pkg::BYTES_W-1:0]    out_granted_bytes,
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tdba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tdba_pkg::ADDR_W-1:0]     cfg_data
);

  localparam int UW = tdba_pkg::UNITS_W;

  tdba_pkg::cfg_t cfg_r, cfg_nxt;
  logic           cfg_we;

  // front to queue
  logic           push_valid;
  logic           push_full;
  tdba_pkg::req_t push_item;

  // queue to back end
  logic           q_valid;
  logic           q_pop;
  tdba_pkg::req_t q_item;

  // config writes are always taken; indexes past the list are dropped
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    unique case (cfg_index)
      tdba_pkg::REG_REGION_BASE:  cfg_nxt.base[0]  = cfg_data;
      tdba_pkg::REG_LEVEL1_BASE:  cfg_nxt.base[1]  = cfg_data;
      tdba_pkg::REG_LEVEL2_BASE:  cfg_nxt.base[2]  = cfg_data;
      tdba_pkg::REG_LEVEL0_UNITS: cfg_nxt.units[0] = cfg_data[UW-1:0];
      tdba_pkg::REG_LEVEL1_UNITS: cfg_nxt.units[1] = cfg_data[UW-1:0];
      tdba_pkg::REG_LEVEL2_UNITS: cfg_nxt.units[2] = cfg_data[UW-1:0];
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      cfg_r <= cfg_nxt;
    end
  end

  // front end: takes a request and sorts it into a size class
  tdba_front #(
    .LEVEL0_BLOCKS (LEVEL0_BLOCKS),
    .LEVEL1_BLOCKS (LEVEL1_BLOCKS),
    .LEVEL2_BLOCKS (LEVEL2_BLOCKS),
    .BLOCK_BYTES   (BLOCK_BYTES)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_request_blocks (in_request_blocks),
    .in_buffer_bytes   (in_buffer_bytes),
    .in_buffer_slot    (in_buffer_slot),
    .push_valid        (push_valid),
    .push_full         (push_full),
    .push_item         (push_item)
  );

  // short queue so the front keeps taking requests while the back end works
  tdba_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_full  (push_full),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  // back end: free lists, slot choice, address math and the output register
  tdba_back #(
    .LEVEL0_BLOCKS (LEVEL0_BLOCKS),
    .LEVEL1_BLOCKS (LEVEL1_BLOCKS),
    .LEVEL2_BLOCKS (LEVEL2_BLOCKS),
    .BLOCK_BYTES   (BLOCK_BYTES),
    .MAX_SLOTS     (MAX_SLOTS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .q_valid             (q_valid),
    .q_pop               (q_pop),
    .q_item              (q_item),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_granted_level   (out_granted_level),
    .out_granted_slot    (out_granted_slot),
    .out_granted_address (out_granted_address),
    .out_granted_bytes   (out_granted_bytes)
  );

endmodule
